FILE: rtl/byr_pkg.sv
// shared types and constants for the byte-run row encoder
`default_nettype none

package byr_pkg;

    // longest row and the width of every byte counter
    localparam int MAX_ROW = 63;
    localparam int CNT_W   = 6;
    localparam int BYTE_W  = 8;

    // configuration port
    localparam int APB_AW  = 3;
    localparam int APB_DW  = 32;
    localparam logic [0:0] REG_ROW_BYTES = 1'b0;
    localparam logic [CNT_W-1:0] ROW_BYTES_RST = CNT_W'(40);

    // run lengths that decide between a replicate run and a fold
    localparam logic [CNT_W-1:0] RUN_MIN_ALONE = CNT_W'(2);
    localparam logic [CNT_W-1:0] RUN_MIN_AFTER = CNT_W'(3);

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_FOLD,
        S_LHDR,
        S_LDATA,
        S_RHDR,
        S_RVAL
    } byr_state_t;

    // one code byte offered to the output stage
    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] code;
        logic              last;
        logic              done;
    } emit_t;

    // literal store access from the sequencer
    typedef struct packed {
        logic              we;
        logic [CNT_W-1:0]  waddr;
        logic [BYTE_W-1:0] wdata;
        logic              re;
        logic [CNT_W-1:0]  raddr;
    } lit_mem_req_t;

endpackage

`default_nettype wire

FILE: rtl/byr_lit_mem.sv
// literal byte store, one write and one registered read port
`default_nettype none

module byr_lit_mem (
    input  wire logic                        aclk,
    input  wire byr_pkg::lit_mem_req_t       req,
    output logic [byr_pkg::BYTE_W-1:0]       rdata
);
    import byr_pkg::*;

    logic [BYTE_W-1:0] mem [0:MAX_ROW-1];

    // write port
    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.waddr] <= req.wdata;
        end
    end

    // read port, data holds while no read is issued
    always_ff @(posedge aclk) begin
        if (req.re) begin
            rdata <= mem[req.raddr];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/byr_out_reg.sv
// output register for code bytes on the master stream side
`default_nettype none

module byr_out_reg (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire byr_pkg::emit_t              emit,
    output logic                             ready,
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic [byr_pkg::BYTE_W-1:0]       m_tdata,
    output logic                             m_tlast,
    output logic [0:0]                       m_tuser
);
    import byr_pkg::*;

    logic              valid_reg;
    logic              valid_next;
    logic [BYTE_W-1:0] code_reg;
    logic              last_reg;
    logic              done_reg;

    // slot is free when empty or being drained this cycle
    assign ready      = !valid_reg || m_tready;
    assign valid_next = ready ? emit.valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // payload loads with each new transaction
    always_ff @(posedge aclk) begin
        if (ready && emit.valid) begin
            code_reg <= emit.code;
            last_reg <= emit.last;
            done_reg <= emit.done;
        end
    end

    assign m_tvalid   = valid_reg;
    assign m_tdata    = code_reg;
    assign m_tlast    = done_reg;
    assign m_tuser[0] = last_reg;

endmodule

`default_nettype wire

FILE: rtl/byr_ctrl.sv
// sequencer: run tracking, literal folding and code byte emission
`default_nettype none

module byr_ctrl (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic [byr_pkg::CNT_W-1:0]   row_bytes,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [byr_pkg::BYTE_W-1:0]  s_byte,
    output byr_pkg::lit_mem_req_t            mem_req,
    input  wire logic [byr_pkg::BYTE_W-1:0]  mem_rdata,
    output byr_pkg::emit_t                   emit,
    input  wire logic                        out_ready
);
    import byr_pkg::*;

    byr_state_t        state_reg, state_next;
    logic [CNT_W-1:0]  lit_cnt_reg, lit_cnt_next;
    logic [CNT_W-1:0]  run_cnt_reg, run_cnt_next;
    logic [BYTE_W-1:0] run_val_reg, run_val_next;
    logic [CNT_W-1:0]  seen_reg, seen_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [BYTE_W-1:0] pend_reg, pend_next;
    logic              end_reg, end_next;
    logic              tail_reg, tail_next;

    logic              accept;
    logic              first;
    logic              same;
    logic              mid_flush;
    logic [CNT_W-1:0]  run_step;
    logic [CNT_W-1:0]  seen_step;
    logic [CNT_W-1:0]  row_len;
    logic              at_end;
    logic              lit_last;
    logic              run_pend;
    logic              final_byte;
    logic              flush_fin;
    byr_state_t        flush_start;
    byr_state_t        after_mid;

    // decode of the incoming byte against the current run
    assign accept    = s_tvalid && s_tready;
    assign first     = (seen_reg == '0);
    assign same      = (s_byte == run_val_reg);
    assign mid_flush = (lit_cnt_reg != '0) ? (run_cnt_reg >= RUN_MIN_AFTER)
                                           : (run_cnt_reg >= RUN_MIN_ALONE);
    assign run_step  = first ? CNT_W'(1)
                     : ((run_cnt_reg < CNT_W'(MAX_ROW)) ? run_cnt_reg + CNT_W'(1)
                                                        : run_cnt_reg);
    assign seen_step = (seen_reg < CNT_W'(MAX_ROW)) ? seen_reg + CNT_W'(1) : seen_reg;
    assign row_len   = (row_bytes == '0) ? CNT_W'(1) : row_bytes;
    assign at_end    = (seen_step >= row_len);

    // flush progress
    assign lit_last   = (state_reg == S_LDATA) && (idx_reg == lit_cnt_reg - CNT_W'(1));
    assign run_pend   = (run_cnt_reg >= RUN_MIN_ALONE);
    assign final_byte = (lit_last && !run_pend) || (state_reg == S_RVAL);
    assign flush_fin  = out_ready && final_byte;
    assign flush_start = (lit_cnt_reg != '0) ? S_LHDR : S_RHDR;
    assign after_mid   = end_reg ? S_FOLD : S_IDLE;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    if (!first && !same) begin
                        state_next = mid_flush ? flush_start : S_FOLD;
                    end else if (at_end) begin
                        state_next = (run_step < RUN_MIN_AFTER) ? S_FOLD : flush_start;
                    end
                end
            end
            S_FOLD: begin
                if (run_cnt_reg == CNT_W'(1)) begin
                    state_next = tail_reg ? S_LHDR : after_mid;
                end
            end
            S_LHDR: begin
                if (out_ready) state_next = S_LDATA;
            end
            S_LDATA: begin
                if (out_ready && lit_last) begin
                    if (run_pend) state_next = S_RHDR;
                    else          state_next = tail_reg ? S_IDLE : after_mid;
                end
            end
            S_RHDR: begin
                if (out_ready) state_next = S_RVAL;
            end
            S_RVAL: begin
                if (out_ready) state_next = tail_reg ? S_IDLE : after_mid;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // counters and run registers
    always_comb begin
        lit_cnt_next = lit_cnt_reg;
        run_cnt_next = run_cnt_reg;
        run_val_next = run_val_reg;
        seen_next    = seen_reg;
        idx_next     = idx_reg;
        pend_next    = pend_reg;
        end_next     = end_reg;
        tail_next    = tail_reg;
        if (accept) begin
            seen_next = seen_step;
            pend_next = s_byte;
            end_next  = at_end;
            if (first) begin
                lit_cnt_next = '0;
                run_val_next = s_byte;
                run_cnt_next = run_step;
                tail_next    = at_end;
            end else if (same) begin
                run_cnt_next = run_step;
                tail_next    = at_end;
            end else begin
                tail_next    = 1'b0;
            end
        end
        // fold one copy of the run value into the literal
        if (state_reg == S_FOLD) begin
            lit_cnt_next = lit_cnt_reg + CNT_W'(1);
            run_cnt_next = run_cnt_reg - CNT_W'(1);
            if (run_cnt_reg == CNT_W'(1) && !tail_reg) begin
                run_val_next = pend_reg;
                run_cnt_next = CNT_W'(1);
                tail_next    = end_reg;
            end
        end
        // literal read index
        if (out_ready && state_reg == S_LHDR) begin
            idx_next = '0;
        end else if (out_ready && state_reg == S_LDATA && !lit_last) begin
            idx_next = idx_reg + CNT_W'(1);
        end
        // end of a flush
        if (flush_fin) begin
            lit_cnt_next = '0;
            run_cnt_next = '0;
            if (tail_reg) begin
                seen_next = '0;
                tail_next = 1'b0;
            end else begin
                run_val_next = pend_reg;
                run_cnt_next = CNT_W'(1);
                tail_next    = end_reg;
            end
        end
    end

    // outputs to the stream, the output stage and the literal store
    always_comb begin
        s_tready      = (state_reg == S_IDLE);
        emit.valid    = 1'b0;
        emit.code     = run_val_reg;
        emit.last     = final_byte && (tail_reg || !end_reg);
        emit.done     = final_byte && tail_reg;
        mem_req.we    = (state_reg == S_FOLD);
        mem_req.waddr = lit_cnt_reg;
        mem_req.wdata = run_val_reg;
        mem_req.re    = 1'b0;
        mem_req.raddr = idx_reg + CNT_W'(1);
        unique case (state_reg)
            S_LHDR: begin
                emit.valid    = 1'b1;
                emit.code     = BYTE_W'(lit_cnt_reg - CNT_W'(1));
                mem_req.re    = out_ready;
                mem_req.raddr = '0;
            end
            S_LDATA: begin
                emit.valid = 1'b1;
                emit.code  = mem_rdata;
                mem_req.re = out_ready && !lit_last;
            end
            S_RHDR: begin
                emit.valid = 1'b1;
                emit.code  = BYTE_W'(1) - BYTE_W'(run_cnt_reg);
            end
            S_RVAL: begin
                emit.valid = 1'b1;
            end
            S_IDLE, S_FOLD: begin
                emit.valid = 1'b0;
            end
            default: emit.valid = 1'b0;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            lit_cnt_reg <= '0;
            run_cnt_reg <= '0;
            run_val_reg <= '0;
            seen_reg    <= '0;
            idx_reg     <= '0;
            end_reg     <= 1'b0;
            tail_reg    <= 1'b0;
        end else begin
            state_reg   <= state_next;
            lit_cnt_reg <= lit_cnt_next;
            run_cnt_reg <= run_cnt_next;
            run_val_reg <= run_val_next;
            seen_reg    <= seen_next;
            idx_reg     <= idx_next;
            end_reg     <= end_next;
            tail_reg    <= tail_next;
        end
    end

    // held copy of the byte that starts the next run
    always_ff @(posedge aclk) begin
        pend_reg <= pend_next;
    end

    // pending literal and run never hold more bytes than the longest row
    assert property (@(posedge aclk) disable iff (!aresetn)
        ({1'b0, lit_cnt_reg} + {1'b0, run_cnt_reg}) <= (CNT_W + 1)'(MAX_ROW))
        else $error("literal plus run exceeds row limit");

    // the byte that ends a row also ends its burst
    assert property (@(posedge aclk) disable iff (!aresetn)
        emit.valid && emit.done |-> emit.last)
        else $error("row end without burst end");

    // after the row end transaction the sequencer is back at row start
    assert property (@(posedge aclk) disable iff (!aresetn)
        emit.valid && emit.done && out_ready |=> state_reg == S_IDLE && seen_reg == '0)
        else $error("row not restarted after final byte");

    // a fold never starts from an empty run
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_FOLD |-> run_cnt_reg != '0)
        else $error("fold with empty run");

endmodule

`default_nettype wire

FILE: rtl/byterun_row_encoder.sv
// top level of the byte-run row encoder: config register, sequencer, store, output stage
// an item that yields no code byte is taken without a stall; a fold of the run into the
// literal writes each folded byte to the store (at most two per fold, two folds per item)
// code bytes then follow in order, paced by the single read port of the literal
// store, and reach the ports through the output register
// synchronous reset clears control state and sets row_bytes to 40, the store is not cleared
`default_nettype none

module byterun_row_encoder (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // input stream
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [7:0]                    s_tdata,  // [7:0] data_byte
    // result stream
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [7:0]                         m_tdata,  // [7:0] code_byte
    output logic                               m_tlast,  // row_done
    output logic [0:0]                         m_tuser,  // [0] last_of_burst
    // configuration port
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [byr_pkg::APB_AW-1:0]    paddr,
    input  wire logic [byr_pkg::APB_DW-1:0]    pwdata,
    output logic [byr_pkg::APB_DW-1:0]         prdata,
    output logic                               pready
);
    import byr_pkg::*;

    logic [CNT_W-1:0]  row_bytes_reg, row_bytes_next;
    logic              cfg_wr;
    logic              reg_hit;
    lit_mem_req_t      mem_req;
    logic [BYTE_W-1:0] mem_rdata;
    emit_t             emit;
    logic              out_ready;

    // register decode
    assign pready  = 1'b1;
    assign reg_hit = (paddr[APB_AW-1] == REG_ROW_BYTES);
    assign cfg_wr  = psel && penable && pwrite && pready && reg_hit;
    assign row_bytes_next = cfg_wr ? pwdata[CNT_W-1:0] : row_bytes_reg;
    assign prdata  = reg_hit ? APB_DW'(row_bytes_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_bytes_reg <= ROW_BYTES_RST;
        end else begin
            row_bytes_reg <= row_bytes_next;
        end
    end

    // sequencer
    byr_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .row_bytes (row_bytes_reg),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_byte    (s_tdata),
        .mem_req   (mem_req),
        .mem_rdata (mem_rdata),
        .emit      (emit),
        .out_ready (out_ready)
    );

    // literal store
    byr_lit_mem u_lit_mem (
        .aclk  (aclk),
        .req   (mem_req),
        .rdata (mem_rdata)
    );

    // output register
    byr_out_reg u_out_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .emit     (emit),
        .ready    (out_ready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire
